FILE: rtl/jvsrb_pkg.sv
// jvsrb_pkg: types, constants and constant tables of the reply builder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package jvsrb_pkg;
   localparam int REPLY_BYTES = 512;
   localparam int WP_W = $clog2(REPLY_BYTES);
   localparam int NUM_W = 28;
   localparam int DIV_STEPS = NUM_W;
   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [7:0] OP_IDENT = 8'h10;
   localparam logic [7:0] OP_CMDREV = 8'h11;
   localparam logic [7:0] OP_JVSREV = 8'h12;
   localparam logic [7:0] OP_COMVER = 8'h13;
   localparam logic [7:0] OP_FEATURE = 8'h14;
   localparam logic [7:0] OP_SWITCH = 8'h20;
   localparam logic [7:0] OP_COIN = 8'h21;
   localparam logic [7:0] OP_ANALOG = 8'h22;
   localparam logic [7:0] OP_ROTARY = 8'h23;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_CENTER = 2'd2;

   localparam logic [7:0] SYNC_BYTE = 8'hE0;
   localparam logic [7:0] STATUS_OK = 8'h01;
   localparam logic [15:0] GUN_CENTER = 16'h8000;
   localparam logic [7:0] IDENT_LAST = 8'd57;
   localparam logic [7:0] FEATURE_LAST = 8'd16;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIVX_GO, ST_DIVX_WAIT, ST_DIVY_GO, ST_DIVY_WAIT,
      ST_STATUS, ST_BODY, ST_HDR
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [7:0] ident_byte(input logic [5:0] i);
      logic [7:0] tbl [0:57];
      tbl = '{8'h53,8'h45,8'h47,8'h41,8'h20,8'h45,8'h4E,8'h54,8'h45,8'h52,8'h50,8'h52,
              8'h49,8'h53,8'h45,8'h53,8'h2C,8'h4C,8'h54,8'h44,8'h2E,8'h3B,8'h49,8'h2F,
              8'h4F,8'h20,8'h42,8'h44,8'h20,8'h4A,8'h56,8'h53,8'h3B,8'h38,8'h33,8'h37,
              8'h2D,8'h31,8'h33,8'h35,8'h35,8'h31,8'h20,8'h3B,8'h56,8'h65,8'h72,8'h31,
              8'h2E,8'h30,8'h30,8'h3B,8'h39,8'h38,8'h2F,8'h31,8'h30,8'h00};
      return (i <= 6'd57) ? tbl[i] : 8'h00;
   endfunction

   function automatic logic [7:0] feature_byte(input logic [5:0] i);
      logic [7:0] tbl [0:16];
      tbl = '{8'h01,8'h02,8'h0C,8'h00,8'h02,8'h02,8'h00,8'h00,
              8'h03,8'h08,8'h10,8'h00,8'h12,8'h06,8'h00,8'h00,8'h00};
      return (i <= 6'd16) ? tbl[i[4:0]] : 8'h00;
   endfunction
endpackage

FILE: rtl/jvsrb_divider.sv
// jvsrb_divider: restoring divider, one quotient bit per cycle, clamped to 16 bits
// depends on jvsrb_pkg
`timescale 1ns / 1ps
module jvsrb_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [jvsrb_pkg::NUM_W-1:0] numerator,
   input  logic [11:0] divisor,
   output logic [15:0] quotient,
   output jvsrb_pkg::div_status_type status
);
   import jvsrb_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [11:0] rem_ff, rem_in;
   logic [11:0] div_ff, div_in;
   logic [12:0] trial;
   logic ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge = trial >= {1'b0, div_ff};

   always_comb begin
      cnt_in = cnt_ff;
      done_in = 1'b0;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         cnt_in = CNT_W'(DIV_STEPS);
         quo_in = numerator;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         // shift one numerator bit in, one quotient bit out
         rem_in = ge ? 12'(trial - {1'b0, div_ff}) : trial[11:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient = (|quo_ff[NUM_W-1:16]) ? 16'hFFFF : quo_ff[15:0];
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
endmodule

FILE: rtl/jvs_io_board_reply_builder.sv
// jvs_io_board_reply_builder: top level, byte sequencer, config registers, output stage
// depends on jvsrb_pkg and jvsrb_divider
`timescale 1ns / 1ps
// usage
//   req_*  one command per request: opcode, arguments, live cabinet inputs and
//          frame_end; accepted when req_valid is high and req_stall is low
//   rsp_*  one reply byte per transfer with its frame offset, a report-start
//          flag and a flag on the last byte of the request
//   csr_*  register writes (screen width, screen height, centered gun),
//          always ready; write only while the block is idle
// timing
//   the block holds one request at a time; req_stall is high from acceptance
//   until the last byte of that request has been loaded into the output register
//   bytes come out one per cycle while rsp_stall is low, plus 5 header/checksum
//   bytes on frame end; analog requests first run x and y through the shared
//   restoring divider, each as launch, 28 steps and pickup, before the first byte;
//   bytes past the buffer end are dropped, though the sequencer still steps
//   through them
// stall and reset
//   rsp_stall freezes the output register and the byte steps of the sequencer, nothing is lost
//   reset (synchronous) empties the output stage, returns the sequencer to idle,
//   restarts the frame at offset 4 with checksum seed 1, and sets width 640, height 480, gun off-center
module jvs_io_board_reply_builder (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_opcode,
   input  logic [3:0] req_arg_first,
   input  logic [2:0] req_arg_second,
   input  logic [5:0] req_buttons,
   input  logic [15:0] req_coin_count_a,
   input  logic [15:0] req_coin_count_b,
   input  logic signed [12:0] req_gun_x,
   input  logic signed [12:0] req_gun_y,
   input  logic req_frame_end,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_reply_byte,
   output logic [8:0] rsp_byte_position,
   output logic rsp_report_start,
   output logic rsp_last_byte,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [11:0] csr_data
);
   import jvsrb_pkg::*;

   localparam logic [WP_W-1:0] LIMIT = WP_W'(REPLY_BYTES - 1);
   localparam logic [WP_W-1:0] WP_START = WP_W'(4);

   // configuration registers
   logic [11:0] width_ff, height_ff;
   logic center_ff;

   // sequencer state
   state_type state_ff, state_in;
   logic [WP_W-1:0] wp_ff, wp_in;
   logic [7:0] sum_ff, sum_in;
   logic [5:0] idx_ff, idx_in;
   logic [3:0] grp_ff, grp_in;
   logic [1:0] sub_ff, sub_in;
   logic [2:0] hdr_ff, hdr_in;

   // captured request
   logic [7:0] op_ff;
   logic [3:0] a1_ff;
   logic [2:0] a2e_ff;
   logic [5:0] btn_ff;
   logic [13:0] coin_a_ff, coin_b_ff;
   logic signed [12:0] gx_ff, gy_ff;
   logic fend_ff;
   logic [15:0] gun_x_ff, gun_y_ff;
   logic [15:0] gun_x_in, gun_y_in;

   // output stage
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [8:0] rsp_pos_ff, rsp_pos_in;
   logic rsp_start_ff, rsp_start_in;
   logic rsp_last_ff, rsp_last_in;

   // divider interface
   logic div_start;
   logic [NUM_W-1:0] div_num;
   logic [11:0] div_den;
   logic [15:0] div_q;
   div_status_type div_st;

   logic accept, adv_ok, room, body_empty, body_last;
   logic [1:0] smax;
   logic [2:0] a2c;
   logic [3:0] a1_last;
   logic [11:0] pos_sel, ext_sel;
   logic [13:0] coin_sel;
   logic [15:0] word_sel;
   logic [7:0] body_byte, count_byte;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign adv_ok = !rsp_valid_ff || !rsp_stall;
   assign room = (wp_ff < LIMIT);
   assign a2c = (req_arg_second > 3'd4) ? 3'd4 : req_arg_second;
   assign a1_last = a1_ff - 1'b1;
   assign smax = (op_ff == OP_SWITCH) ? 2'(a2e_ff - 3'd1) : 2'd1;
   assign count_byte = 8'(wp_ff - WP_W'(2));

   // gun scaling: numerator is pos*65535, negative clamps to zero
   always_comb begin
      if (state_ff == ST_DIVY_GO) begin
         pos_sel = gy_ff[12] ? 12'd0 : gy_ff[11:0];
         ext_sel = (height_ff == 12'd0) ? 12'd1 : height_ff;
      end else begin
         pos_sel = gx_ff[12] ? 12'd0 : gx_ff[11:0];
         ext_sel = (width_ff == 12'd0) ? 12'd1 : width_ff;
      end
      div_num = {pos_sel, 16'd0} - {16'd0, pos_sel};
      div_den = ext_sel;
      div_start = (state_ff == ST_DIVX_GO) || (state_ff == ST_DIVY_GO);
   end

   jvsrb_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numerator(div_num), .divisor(div_den),
      .quotient(div_q), .status(div_st)
   );

   // current body byte and whether it ends the report
   always_comb begin
      coin_sel = (grp_ff == 4'd0) ? coin_a_ff : ((grp_ff == 4'd1) ? coin_b_ff : 14'd0);
      if (center_ff) word_sel = GUN_CENTER;
      else if (grp_ff == 4'd0 || grp_ff == 4'd2) word_sel = gun_x_ff;
      else if (grp_ff == 4'd1 || grp_ff == 4'd3) word_sel = gun_y_ff;
      else word_sel = GUN_CENTER;
      body_byte = 8'h00;
      body_last = 1'b1;
      body_empty = 1'b1;
      unique case (op_ff)
         OP_IDENT: begin
            body_byte = ident_byte(idx_ff);
            body_last = ({2'b0, idx_ff} == IDENT_LAST);
            body_empty = 1'b0;
         end
         OP_CMDREV: begin body_byte = 8'h13; body_empty = 1'b0; end
         OP_JVSREV: begin body_byte = 8'h30; body_empty = 1'b0; end
         OP_COMVER: begin body_byte = 8'h10; body_empty = 1'b0; end
         OP_FEATURE: begin
            body_byte = feature_byte(idx_ff);
            body_last = ({2'b0, idx_ff} == FEATURE_LAST);
            body_empty = 1'b0;
         end
         OP_SWITCH: begin
            body_empty = 1'b0;
            if (idx_ff == 6'd0) begin
               body_byte = {btn_ff[0], 7'd0};
               body_last = (a1_ff == 4'd0);
            end else begin
               if (sub_ff != 2'd0) body_byte = 8'h00;
               else if (grp_ff == 4'd0)
                  body_byte = {btn_ff[1], btn_ff[2], 4'd0, btn_ff[3], btn_ff[4]};
               else if (grp_ff == 4'd1) body_byte = {btn_ff[5], 7'd0};
               else body_byte = 8'h00;
               body_last = (grp_ff == a1_last) && (sub_ff == smax);
            end
         end
         OP_COIN: begin
            body_byte = (sub_ff == 2'd0) ? {2'b0, coin_sel[13:8]} : coin_sel[7:0];
            body_last = (grp_ff == a1_last) && (sub_ff == 2'd1);
            body_empty = (a1_ff == 4'd0);
         end
         OP_ANALOG: begin
            body_byte = (sub_ff == 2'd0) ? word_sel[15:8] : word_sel[7:0];
            body_last = (grp_ff == a1_last) && (sub_ff == 2'd1);
            body_empty = (a1_ff == 4'd0);
         end
         OP_ROTARY: begin
            body_byte = 8'h00;
            body_last = (grp_ff == a1_last) && (sub_ff == 2'd1);
            body_empty = (a1_ff == 4'd0);
         end
         default: begin
            body_byte = 8'h00;
         end
      endcase
   end

   // sequencer next state and output stage load
   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff;
      sum_in = sum_ff;
      idx_in = idx_ff;
      grp_in = grp_ff;
      sub_in = sub_ff;
      hdr_in = hdr_ff;
      gun_x_in = gun_x_ff;
      gun_y_in = gun_y_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in = rsp_byte_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_start_in = rsp_start_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               grp_in = '0;
               sub_in = '0;
               hdr_in = '0;
               state_in = (req_opcode == OP_ANALOG) ? ST_DIVX_GO : ST_STATUS;
            end
         end
         ST_DIVX_GO: state_in = ST_DIVX_WAIT;
         ST_DIVX_WAIT: begin
            if (div_st.done) begin
               gun_x_in = div_q;
               state_in = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO: state_in = ST_DIVY_WAIT;
         ST_DIVY_WAIT: begin
            if (div_st.done) begin
               gun_y_in = div_q;
               state_in = ST_STATUS;
            end
         end
         ST_STATUS, ST_BODY: begin
            if (adv_ok) begin
               if (room) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in = (state_ff == ST_STATUS) ? STATUS_OK : body_byte;
                  rsp_pos_in = 9'(wp_ff);
                  rsp_start_in = (state_ff == ST_STATUS);
                  // last result unless a frame end follows: end of report, or the byte that fills the buffer
                  rsp_last_in = !fend_ff &&
                     (((state_ff == ST_STATUS) ? body_empty : body_last) ||
                      (wp_ff == LIMIT - 1'b1));
                  wp_in = wp_ff + 1'b1;
                  sum_in = sum_ff + rsp_byte_in;
               end
               if (state_ff == ST_STATUS) begin
                  if (body_empty) state_in = fend_ff ? ST_HDR : ST_IDLE;
                  else state_in = ST_BODY;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  if (op_ff != OP_SWITCH || idx_ff != 6'd0) begin
                     if (sub_ff == smax) begin
                        sub_in = '0;
                        grp_in = grp_ff + 1'b1;
                     end else begin
                        sub_in = sub_ff + 1'b1;
                     end
                  end
                  if (body_last) state_in = fend_ff ? ST_HDR : ST_IDLE;
               end
            end
         end
         ST_HDR: begin
            if (adv_ok) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = (hdr_ff == 3'd3);
               rsp_last_in = (hdr_ff == 3'd4);
               rsp_pos_in = 9'(hdr_ff);
               unique case (hdr_ff)
                  3'd0: rsp_byte_in = SYNC_BYTE;
                  3'd1: rsp_byte_in = 8'h00;
                  3'd2: rsp_byte_in = count_byte;
                  3'd3: rsp_byte_in = STATUS_OK;
                  default: begin
                     rsp_byte_in = sum_ff + count_byte;
                     rsp_pos_in = 9'(wp_ff);
                  end
               endcase
               hdr_in = hdr_ff + 1'b1;
               if (hdr_ff == 3'd4) begin
                  wp_in = WP_START;
                  sum_in = 8'd1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff <= WP_START;
         sum_ff <= 8'd1;
         rsp_valid_ff <= 1'b0;
         width_ff <= 12'd640;
         height_ff <= 12'd480;
         center_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff <= wp_in;
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_WIDTH: width_ff <= csr_data;
               REG_HEIGHT: height_ff <= csr_data;
               REG_CENTER: center_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
      idx_ff <= idx_in;
      grp_ff <= grp_in;
      sub_ff <= sub_in;
      hdr_ff <= hdr_in;
      gun_x_ff <= gun_x_in;
      gun_y_ff <= gun_y_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_start_ff <= rsp_start_in;
      rsp_last_ff <= rsp_last_in;
      if (accept) begin
         // capture with argument saturation
         op_ff <= req_opcode;
         a1_ff <= (req_arg_first > 4'd8) ? 4'd8 : req_arg_first;
         a2e_ff <= (a2c == 3'd0) ? 3'd1 : a2c;
         btn_ff <= req_buttons;
         coin_a_ff <= req_coin_count_a[13:0];
         coin_b_ff <= req_coin_count_b[13:0];
         gx_ff <= req_gun_x;
         gy_ff <= req_gun_y;
         fend_ff <= req_frame_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_reply_byte = rsp_byte_ff;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_report_start = rsp_start_ff;
   assign rsp_last_byte = rsp_last_ff;
endmodule

FILE: rtl/jvsrb_checker.sv
// jvsrb_checker: port-level assertions for the reply builder, bound to the top level
// depends on jvsrb_pkg
`timescale 1ns / 1ps
module jvsrb_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic [7:0] rsp_reply_byte,
   input  logic [8:0] rsp_byte_position,
   input  logic rsp_report_start
);
   import jvsrb_pkg::*;

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_reply_byte)
         && $stable(rsp_byte_position)))
      else $error("stalled result changed");

   // report start always carries the status byte
   a_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_report_start) |-> (rsp_reply_byte == STATUS_OK))
      else $error("report start without status byte");

   // offset zero only ever holds the sync byte
   a_sync: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_position == 9'd0) |-> (rsp_reply_byte == SYNC_BYTE))
      else $error("bad sync byte");
endmodule

bind jvs_io_board_reply_builder jvsrb_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_reply_byte(rsp_reply_byte),
   .rsp_byte_position(rsp_byte_position), .rsp_report_start(rsp_report_start)
);

FILE: tb/jvs_io_board_reply_builder_test.sv
// jvs_io_board_reply_builder_test: self-checking bench for the reply builder
// depends on jvsrb_pkg and the jvs_io_board_reply_builder rtl
`timescale 1ns / 1ps
module jvs_io_board_reply_builder_test;
   import jvsrb_pkg::*;

   // one command request as presented on the req_ ports
   typedef struct {
      logic [7:0] opcode;
      logic [3:0] arg_first;
      logic [2:0] arg_second;
      logic [5:0] buttons;
      logic [15:0] coin_a;
      logic [15:0] coin_b;
      logic signed [12:0] gun_x;
      logic signed [12:0] gun_y;
      logic frame_end;
   } command_type;

   // one byte of the acknowledge frame as seen on the rsp_ ports
   typedef struct {
      logic [7:0] data;
      logic [8:0] position;
      logic start;
      logic last;
   } reply_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_opcode = 0;
   logic [3:0] req_arg_first = 0;
   logic [2:0] req_arg_second = 0;
   logic [5:0] req_buttons = 0;
   logic [15:0] req_coin_count_a = 0;
   logic [15:0] req_coin_count_b = 0;
   logic signed [12:0] req_gun_x = 0;
   logic signed [12:0] req_gun_y = 0;
   logic req_frame_end = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [7:0] rsp_reply_byte;
   logic [8:0] rsp_byte_position;
   logic rsp_report_start;
   logic rsp_last_byte;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = 0;
   logic [11:0] csr_data = 0;

   jvs_io_board_reply_builder uut (.*);

   // pending commands and expected reply bytes
   command_type command_q[$];
   reply_type reply_q[$];
   int errors = 0;

   // shadow of the block's registers and frame state
   logic [11:0] width_reg = 12'd640;
   logic [11:0] height_reg = 12'd480;
   logic center_reg = 0;
   int frame_pos = 4;
   logic [7:0] frame_sum = 8'd1;

   // traffic shaping knobs, set per phase
   bit no_gaps = 0;
   bit no_stalls = 0;
   int hold_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;

   logic [7:0] ident_rom [0:57] = '{
      8'h53,8'h45,8'h47,8'h41,8'h20,8'h45,8'h4E,8'h54,8'h45,8'h52,8'h50,8'h52,
      8'h49,8'h53,8'h45,8'h53,8'h2C,8'h4C,8'h54,8'h44,8'h2E,8'h3B,8'h49,8'h2F,
      8'h4F,8'h20,8'h42,8'h44,8'h20,8'h4A,8'h56,8'h53,8'h3B,8'h38,8'h33,8'h37,
      8'h2D,8'h31,8'h33,8'h35,8'h35,8'h31,8'h20,8'h3B,8'h56,8'h65,8'h72,8'h31,
      8'h2E,8'h30,8'h30,8'h3B,8'h39,8'h38,8'h2F,8'h31,8'h30,8'h00};
   logic [7:0] feature_rom [0:16] = '{
      8'h01,8'h02,8'h0C,8'h00,8'h02,8'h02,8'h00,8'h00,
      8'h03,8'h08,8'h10,8'h00,8'h12,8'h06,8'h00,8'h00,8'h00};

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #30ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // append one payload byte unless the frame buffer is full
   function automatic void add_byte(input logic [7:0] b, input logic st, inout int n);
      reply_type r;
      if (frame_pos >= REPLY_BYTES - 1) return;
      r.data = b;
      r.position = frame_pos[8:0];
      r.start = st;
      r.last = 0;
      reply_q.push_back(r);
      n++;
      frame_pos++;
      frame_sum += b;
   endfunction

   function automatic void add_raw(input logic [7:0] b, input int pos, input logic st,
                                   inout int n);
      reply_type r;
      r.data = b;
      r.position = pos[8:0];
      r.start = st;
      r.last = 0;
      reply_q.push_back(r);
      n++;
   endfunction

   // gun pixel position to 0..65535, clamped
   function automatic logic [15:0] gun_scale(input logic signed [12:0] p,
                                             input logic [11:0] ext);
      longint q;
      longint e;
      e = (ext == 0) ? 1 : ext;
      if (p < 0) return 16'd0;
      q = (longint'(p) * 65535) / e;
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   // expected reply bytes for one accepted command
   function automatic void predict_reply(input command_type c);
      int n;
      int a1;
      int a2;
      logic [7:0] b0;
      logic [15:0] v;
      logic [15:0] gx;
      logic [15:0] gy;
      logic [7:0] cnt;
      n = 0;
      a1 = (c.arg_first > 8) ? 8 : c.arg_first;
      a2 = (c.arg_second > 4) ? 4 : c.arg_second;
      gx = gun_scale(c.gun_x, width_reg);
      gy = gun_scale(c.gun_y, height_reg);
      add_byte(STATUS_OK, 1, n);
      case (c.opcode)
         OP_IDENT: for (int i = 0; i < 58; i++) add_byte(ident_rom[i], 0, n);
         OP_CMDREV: add_byte(8'h13, 0, n);
         OP_JVSREV: add_byte(8'h30, 0, n);
         OP_COMVER: add_byte(8'h10, 0, n);
         OP_FEATURE: for (int i = 0; i < 17; i++) add_byte(feature_rom[i], 0, n);
         OP_SWITCH: begin
            add_byte(c.buttons[0] ? 8'h80 : 8'h00, 0, n);
            for (int i = 0; i < a1; i++) begin
               b0 = 0;
               if (i == 0) b0 = {c.buttons[1], c.buttons[2], 4'b0, c.buttons[3], c.buttons[4]};
               else if (i == 1) b0 = {c.buttons[5], 7'b0};
               add_byte(b0, 0, n);
               // a player always gets a first byte, even at zero bytes per player
               for (int k = 1; k < a2; k++) add_byte(8'h00, 0, n);
            end
         end
         OP_COIN: begin
            for (int i = 0; i < a1; i++) begin
               v = (i == 0) ? c.coin_a : (i == 1) ? c.coin_b : 16'd0;
               v &= 16'h3FFF;
               add_byte(v[15:8], 0, n);
               add_byte(v[7:0], 0, n);
            end
         end
         OP_ANALOG: begin
            for (int i = 0; i < a1; i++) begin
               if (center_reg) v = GUN_CENTER;
               else if (i == 0 || i == 2) v = gx;
               else if (i == 1 || i == 3) v = gy;
               else v = GUN_CENTER;
               add_byte(v[15:8], 0, n);
               add_byte(v[7:0], 0, n);
            end
         end
         OP_ROTARY: for (int i = 0; i < a1 * 2; i++) add_byte(8'h00, 0, n);
         default: ;
      endcase
      if (c.frame_end) begin
         cnt = 8'(frame_pos - 2);
         add_raw(SYNC_BYTE, 0, 0, n);
         add_raw(8'h00, 1, 0, n);
         add_raw(cnt, 2, 0, n);
         add_raw(STATUS_OK, 3, 1, n);
         add_raw(frame_sum + cnt, frame_pos, 0, n);
         frame_pos = 4;
         frame_sum = 8'd1;
      end
      if (n > 0) reply_q[$].last = 1;
   endfunction

   task automatic present_command(input command_type c);
      req_opcode <= c.opcode;
      req_arg_first <= c.arg_first;
      req_arg_second <= c.arg_second;
      req_buttons <= c.buttons;
      req_coin_count_a <= c.coin_a;
      req_coin_count_b <= c.coin_b;
      req_gun_x <= c.gun_x;
      req_gun_y <= c.gun_y;
      req_frame_end <= c.frame_end;
   endtask

   // request driver: holds the queue front until accepted, then idles at random
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid) begin
         if (!req_stall) begin
            predict_reply(command_q[0]);
            void'(command_q.pop_front());
            send_gap = no_gaps ? 0 : $urandom_range(0, 12);
            if (send_gap == 0 && command_q.size() > 0) begin
               present_command(command_q[0]);
            end else begin
               req_valid <= 0;
            end
         end
      end else if (send_gap > 0) begin
         send_gap--;
      end else if (command_q.size() > 0) begin
         present_command(command_q[0]);
         req_valid <= 1;
      end
   end

   // reply receiver: random stall per byte, plus the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            recv_gap = no_stalls ? 0 : $urandom_range(0, 12);
         else if (hold_cycles > 0)
            hold_cycles--;
         else if (recv_gap > 0)
            recv_gap--;
         rsp_stall <= (hold_cycles > 0) || (recv_gap > 0);
      end
   end

   // reply checker: each accepted byte against the oldest expectation
   always @(posedge clock) begin
      reply_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h at %0d",
                                      rsp_reply_byte, rsp_byte_position));
         end else begin
            e = reply_q.pop_front();
            if (rsp_reply_byte !== e.data)
               report_mismatch($sformatf("byte %h, want %h at position %0d",
                                         rsp_reply_byte, e.data, e.position));
            if (rsp_byte_position !== e.position)
               report_mismatch($sformatf("position %0d, want %0d",
                                         rsp_byte_position, e.position));
            if (rsp_report_start !== e.start)
               report_mismatch($sformatf("report_start %b, want %b at %0d",
                                         rsp_report_start, e.start, e.position));
            if (rsp_last_byte !== e.last)
               report_mismatch($sformatf("last_byte %b, want %b at %0d",
                                         rsp_last_byte, e.last, e.position));
         end
      end
   end

   function automatic command_type make_command(input logic [7:0] op, input int a1,
                                                input int a2, input bit fend);
      command_type c;
      c.opcode = op;
      c.arg_first = 4'(a1);
      c.arg_second = 3'(a2);
      c.buttons = 6'($urandom_range(0, 63));
      c.coin_a = 16'($urandom_range(0, 65535));
      c.coin_b = 16'($urandom_range(0, 65535));
      c.gun_x = 13'($urandom_range(0, 8191));
      c.gun_y = 13'($urandom_range(0, 8191));
      c.frame_end = fend;
      return c;
   endfunction

   // random command, mostly known opcodes; end_odds sets how long frames run
   function automatic command_type random_command(input int end_odds);
      logic [7:0] op;
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0, 1, 2: op = OP_IDENT;
         3: op = OP_CMDREV;
         4: op = OP_JVSREV;
         5: op = OP_COMVER;
         6, 7: op = OP_FEATURE;
         8, 9, 10: op = OP_SWITCH;
         11, 12: op = OP_COIN;
         13, 14, 15: op = OP_ANALOG;
         16, 17: op = OP_ROTARY;
         default: op = 8'($urandom_range(0, 255));
      endcase
      return make_command(op, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, 8),
                          $urandom_range(0, 7), $urandom_range(0, end_odds - 1) == 0);
   endfunction

   // wait until every queued command is done, then let the block settle
   task automatic drain;
      while (command_q.size() > 0 || reply_q.size() > 0) @(posedge clock);
      // a command past the buffer end may still be stepping with nothing expected
      repeat (200) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [11:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
      csr_valid <= 0;
      case (idx)
         REG_WIDTH: width_reg = val;
         REG_HEIGHT: height_reg = val;
         REG_CENTER: center_reg = val[0];
         default: ;
      endcase
   endtask

   task automatic random_phase(input int count, input int end_odds);
      @(negedge clock);
      for (int i = 0; i < count; i++) command_q.push_back(random_command(end_odds));
      drain();
   endtask

   initial begin
      command_type c;
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed: every opcode, argument and input extremes, gun clamping
      @(negedge clock);
      c = make_command(OP_IDENT, 0, 0, 0); command_q.push_back(c);
      c = make_command(OP_CMDREV, 0, 0, 0); command_q.push_back(c);
      c = make_command(OP_JVSREV, 0, 0, 0); command_q.push_back(c);
      c = make_command(OP_COMVER, 0, 0, 1); command_q.push_back(c);
      c = make_command(OP_FEATURE, 0, 0, 0); command_q.push_back(c);
      c = make_command(OP_SWITCH, 2, 0, 0); c.buttons = 6'h3F; command_q.push_back(c);
      c = make_command(OP_SWITCH, 15, 7, 0); c.buttons = 6'h00; command_q.push_back(c);
      c = make_command(OP_SWITCH, 8, 4, 1); c.buttons = 6'h15; command_q.push_back(c);
      c = make_command(OP_COIN, 4, 0, 0);
      c.coin_a = 16'hFFFF; c.coin_b = 16'h0000; command_q.push_back(c);
      c = make_command(OP_COIN, 15, 0, 0);
      c.coin_a = 16'h0000; c.coin_b = 16'hFFFF; command_q.push_back(c);
      c = make_command(OP_ANALOG, 8, 0, 0);
      c.gun_x = -13'sd4096; c.gun_y = 13'sd4095; command_q.push_back(c);
      c = make_command(OP_ANALOG, 15, 0, 0);
      c.gun_x = 13'sd4095; c.gun_y = -13'sd1; command_q.push_back(c);
      c = make_command(OP_ANALOG, 4, 0, 1);
      c.gun_x = 13'sd0; c.gun_y = 13'sd0; command_q.push_back(c);
      c = make_command(OP_ROTARY, 8, 0, 0); command_q.push_back(c);
      c = make_command(OP_ROTARY, 15, 0, 0); command_q.push_back(c);
      c = make_command(8'h00, 0, 0, 0); command_q.push_back(c);
      c = make_command(8'hFF, 0, 0, 1); command_q.push_back(c);
      // fill the buffer with identity reports, then overflow and close the frame
      for (int i = 0; i < 9; i++) begin
         c = make_command(OP_IDENT, 0, 0, 0); command_q.push_back(c);
      end
      c = make_command(OP_ROTARY, 8, 0, 0); command_q.push_back(c);
      c = make_command(OP_COMVER, 0, 0, 1); command_q.push_back(c);
      drain();

      // full-scale screen, no idling on either side
      no_gaps = 1;
      no_stalls = 1;
      write_register(REG_WIDTH, 12'd4095);
      write_register(REG_HEIGHT, 12'd4095);
      random_phase(60, 6);
      no_gaps = 0;
      no_stalls = 0;

      // tiny screen so most positions clamp; long frames hit the buffer end
      write_register(REG_WIDTH, 12'd1);
      write_register(REG_HEIGHT, 12'd1);
      random_phase(80, 25);

      // centered gun with a long receiver hold-off while requests keep coming
      write_register(REG_CENTER, 12'd1);
      hold_cycles = 600;
      random_phase(70, 5);

      // back to off-center, mid-range screen
      write_register(REG_CENTER, 12'd0);
      write_register(REG_WIDTH, 12'd320);
      write_register(REG_HEIGHT, 12'd2047);
      random_phase(80, 8);

      // random extents
      write_register(REG_WIDTH, 12'($urandom_range(1, 4095)));
      write_register(REG_HEIGHT, 12'($urandom_range(1, 4095)));
      random_phase(60, 4);

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
